// ===== rtl/sil_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial image loader package
// Shared widths, header layout constants and the result word type.
// ----------------------------------------------------------------------------
package sil_pkg;

  // Field widths of the channel words
  localparam int ByteW = 8;
  localparam int AddrW = 32;
  localparam int LenW  = 32;
  localparam int SumW  = 40;
  localparam int HcW   = 4;

  // Header layout: four length bytes, then five expected-sum bytes
  localparam logic [HcW-1:0] LenBytes = 4'd4;
  localparam logic [HcW-1:0] HdrBytes = 4'd9;
  localparam logic [HcW-1:0] HdrLast  = 4'd8;

  // Load base after reset
  localparam logic [AddrW-1:0] LoadBaseReset = 32'h0008_0000;

  // One result word
  typedef struct packed {
    logic             write_valid;
    logic [AddrW-1:0] write_addr;
    logic [ByteW-1:0] write_data;
    logic             done_res;
    logic             checksum_ok;
  } sil_result_t;

endpackage

// ===== rtl/sil_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial image loader input channel
// Valid/ready channel carrying one received byte per word.
// ----------------------------------------------------------------------------
interface sil_in_if;
  import sil_pkg::*;

  logic             valid;
  logic             ready;
  logic [ByteW-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

// ===== rtl/sil_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial image loader result channel
// Valid/ready channel carrying a memory write and/or a checksum verdict.
// ----------------------------------------------------------------------------
interface sil_out_if;
  import sil_pkg::*;

  logic             valid;
  logic             ready;
  logic             write_valid;
  logic [AddrW-1:0] write_addr;
  logic [ByteW-1:0] write_data;
  logic             done_res;
  logic             checksum_ok;

  modport source (output valid, output write_valid, output write_addr,
                  output write_data, output done_res, output checksum_ok,
                  input ready);
  modport sink (input valid, input write_valid, input write_addr,
                input write_data, input done_res, input checksum_ok,
                output ready);
endinterface

// ===== rtl/sil_out_stage.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial image loader output register
// Holds one result word until the sink takes it; reports space for a new one.
// ----------------------------------------------------------------------------
module sil_out_stage (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load,
  input  sil_pkg::sil_result_t res,
  output logic                space,
  sil_out_if.source           out_ch
);
  import sil_pkg::*;

  logic        valid_r;
  logic        valid_nxt;
  sil_result_t data_r;

  // The register may be refilled in the cycle its word leaves.
  assign space = !valid_r || out_ch.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= res;
    end
  end

  assign out_ch.valid       = valid_r;
  assign out_ch.write_valid = data_r.write_valid;
  assign out_ch.write_addr  = data_r.write_addr;
  assign out_ch.write_data  = data_r.write_data;
  assign out_ch.done_res    = data_r.done_res;
  assign out_ch.checksum_ok = data_r.checksum_ok;

endmodule

// ===== rtl/serial_image_loader_unit.sv =====
`timescale 1ns / 1ps
// A result word is registered and appears on the output in the cycle after its byte is accepted.
// One byte is taken per cycle; the input stalls only while a result waits unread.
// Header bytes other than the ninth (with a zero length) produce no result word.
// Reset is synchronous and active low: header, index and sum state clear, the
// load base returns to 0x80000 and the output register empties.
// ----------------------------------------------------------------------------
// Serial image loader
// Parses a length/expected-sum header, emits payload bytes as memory writes
// and reports whether the additive checksum of the payload matched.
// ----------------------------------------------------------------------------
module serial_image_loader_unit #(
  parameter int ADDR_WIDTH = 32
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_we,
  input  logic [sil_pkg::AddrW-1:0] cfg_wdata,
  sil_in_if.sink                  in_ch,
  sil_out_if.source               out_ch
);
  import sil_pkg::*;

  // Addresses wrap at ADDR_WIDTH bits, or at 32 (the result field width) when ADDR_WIDTH is larger.
  localparam int               AddrKeep = (ADDR_WIDTH < AddrW) ? ADDR_WIDTH : AddrW;
  localparam logic [AddrW-1:0] AddrMask = {AddrW{1'b1}} >> (AddrW - AddrKeep);

  logic [AddrW-1:0] load_base_r;
  logic [HcW-1:0]   header_count_r, header_count_nxt;
  logic [LenW-1:0]  image_length_r, image_length_nxt;
  logic [SumW-1:0]  expected_sum_r, expected_sum_nxt;
  logic [LenW-1:0]  byte_index_r, byte_index_nxt;
  logic [SumW-1:0]  running_sum_r, running_sum_nxt;

  logic             accept;
  logic             has_res;
  logic             space;
  sil_result_t      res;
  logic [LenW-1:0]  index_inc;
  logic [SumW-1:0]  sum_add;

  assign in_ch.ready = space;
  assign accept      = in_ch.valid && space;

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      load_base_r <= LoadBaseReset;
    end else if (cfg_we) begin
      load_base_r <= cfg_wdata;
    end
  end

  assign index_inc = byte_index_r + 1'b1;
  assign sum_add   = running_sum_r + {{(SumW-ByteW){1'b0}}, in_ch.rx_byte};

  // Header parsing, payload addressing and checksum for the byte on the input
  always_comb begin
    header_count_nxt = header_count_r;
    image_length_nxt = image_length_r;
    expected_sum_nxt = expected_sum_r;
    byte_index_nxt   = byte_index_r;
    running_sum_nxt  = running_sum_r;
    has_res          = 1'b0;
    res              = '0;
    if (header_count_r < HdrBytes) begin
      if (header_count_r < LenBytes) begin
        image_length_nxt = {image_length_r[LenW-ByteW-1:0], in_ch.rx_byte};
      end else begin
        expected_sum_nxt = {expected_sum_r[SumW-ByteW-1:0], in_ch.rx_byte};
      end
      header_count_nxt = header_count_r + 1'b1;
      if (header_count_r == HdrLast) begin
        byte_index_nxt  = '0;
        running_sum_nxt = '0;
        // An empty image completes as soon as the header is in.
        if (image_length_r == '0) begin
          has_res          = 1'b1;
          res.done_res     = 1'b1;
          res.checksum_ok  = (expected_sum_nxt == '0);
          header_count_nxt = '0;
        end
      end
    end else begin
      has_res         = 1'b1;
      res.write_valid = 1'b1;
      res.write_addr  = (load_base_r + byte_index_r) & AddrMask;
      res.write_data  = in_ch.rx_byte;
      running_sum_nxt = sum_add;
      byte_index_nxt  = index_inc;
      // Last payload byte: verdict includes this byte, then back to header.
      if (index_inc >= image_length_r) begin
        res.done_res     = 1'b1;
        res.checksum_ok  = (sum_add == expected_sum_r);
        header_count_nxt = '0;
        byte_index_nxt   = '0;
        running_sum_nxt  = '0;
      end
    end
  end

  // Loader state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_count_r <= '0;
      image_length_r <= '0;
      expected_sum_r <= '0;
      byte_index_r   <= '0;
      running_sum_r  <= '0;
    end else if (accept) begin
      header_count_r <= header_count_nxt;
      image_length_r <= image_length_nxt;
      expected_sum_r <= expected_sum_nxt;
      byte_index_r   <= byte_index_nxt;
      running_sum_r  <= running_sum_nxt;
    end
  end

  // Result register towards the sink
  sil_out_stage u_out_stage (
    .clk    (clk),
    .rst_n  (rst_n),
    .load   (accept && has_res),
    .res    (res),
    .space  (space),
    .out_ch (out_ch)
  );

endmodule

// ===== rtl/sil_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial image loader port checker
// Watches the result channel of the top level for consistency over time.
// ----------------------------------------------------------------------------
module sil_checker (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic                    write_valid,
  input logic [sil_pkg::AddrW-1:0] write_addr,
  input logic [sil_pkg::ByteW-1:0] write_data,
  input logic                    done_res,
  input logic                    checksum_ok
);
  import sil_pkg::*;

  // A stalled word stays put.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(write_addr)
      && $stable(write_data) && $stable(done_res) && $stable(checksum_ok))
    else $error("result word changed while stalled");

  // A word that writes nothing must carry a verdict.
  a_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !write_valid |-> done_res)
    else $error("empty result word");

  // Without a write, address and data are zero.
  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !write_valid |-> write_addr == '0 && write_data == '0)
    else $error("stray write payload");

  // No verdict, no pass flag.
  a_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !done_res |-> !checksum_ok)
    else $error("checksum flag without completion");

  // Reset empties the output register.
  a_rst: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result pending after reset");

endmodule

bind serial_image_loader_unit sil_checker u_sil_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .write_valid (out_ch.write_valid),
  .write_addr  (out_ch.write_addr),
  .write_data  (out_ch.write_data),
  .done_res    (out_ch.done_res),
  .checksum_ok (out_ch.checksum_ok)
);

// ===== dv/serial_image_loader_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial image loader testbench
// Streams image headers and payloads into the loader, including zero-length
// images, bad checksums, misaligned garbage and wrapping load bases. A
// predictor tracks the header and payload state and queues the memory writes
// and verdicts it expects. Every result word is compared field by field.
// ----------------------------------------------------------------------------
module serial_image_loader_unit_tb;
  import sil_pkg::*;

  localparam int QuietLimit  = 1000;
  localparam int DrainCycles = 4;
  localparam int PhaseBytes  = 60;
  localparam int NumPhases   = 8;

  typedef enum int {SumMatch, SumNear, SumRandom} sum_kind_e;

  logic             clk = 1'b0;
  logic             rst_n;
  logic             cfg_we;
  logic [AddrW-1:0] cfg_wdata;

  sil_in_if  in_ch();
  sil_out_if out_ch();

  serial_image_loader_unit uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  // Predicted loader state and the words still owed by the block.
  logic [AddrW-1:0] base_addr;
  logic [HcW-1:0]   hdr_taken;
  logic [LenW-1:0]  img_len;
  logic [SumW-1:0]  want_sum;
  logic [LenW-1:0]  pay_idx;
  logic [SumW-1:0]  pay_sum;
  sil_result_t      awaited_words[$];

  int mismatch_count = 0;
  int bytes_sent     = 0;
  int quiet_cycles   = 0;
  bit src_gaps_on    = 1'b0;
  bit sink_stalls_on = 1'b0;

  // Long hold requests for the receiver, counted down in its own process.
  int hold_token = 0;
  int hold_seen  = 0;
  int hold_len   = 0;
  int hold_left  = 0;
  int stall_left = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Receiver: random stall bursts, or a long hold when one is requested.
  always @(posedge clk) begin
    if (hold_token != hold_seen) begin
      hold_seen    <= hold_token;
      hold_left    <= hold_len;
      out_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left    <= hold_left - 1;
      out_ch.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left   <= stall_left - 1;
      out_ch.ready <= 1'b0;
    end else if (sink_stalls_on && $urandom_range(0, 5) == 0) begin
      stall_left   <= $urandom_range(0, 3);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // Compare one field of a result word and log any difference.
  task automatic compare_field(input string name, input logic [SumW-1:0] want,
                               input logic [SumW-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  // Result checker. Sampling on the falling edge sees settled handshakes.
  always @(negedge clk) begin : result_check
    sil_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (awaited_words.size() == 0) begin
        $display("%0t: unexpected word, expected none, got wv=%b addr=%h data=%h done=%b ok=%b",
                 $time, out_ch.write_valid, out_ch.write_addr, out_ch.write_data,
                 out_ch.done_res, out_ch.checksum_ok);
        mismatch_count++;
      end else begin
        want = awaited_words.pop_front();
        compare_field("write_valid", want.write_valid, out_ch.write_valid);
        compare_field("write_addr", want.write_addr, out_ch.write_addr);
        compare_field("write_data", want.write_data, out_ch.write_data);
        compare_field("done_res", want.done_res, out_ch.done_res);
        compare_field("checksum_ok", want.checksum_ok, out_ch.checksum_ok);
      end
    end
  end

  // Watchdog: too many cycles without any word moving ends the run.
  always @(negedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles = quiet_cycles + 1;
    end
    if (quiet_cycles >= QuietLimit) begin
      $display("serial_image_loader_unit_tb: errors");
      $finish;
    end
  end

  // Advance the predicted loader by one accepted byte.
  task automatic track_loader_byte(input logic [ByteW-1:0] b);
    sil_result_t word;
    word = '0;
    if (hdr_taken < HdrBytes) begin
      if (hdr_taken < LenBytes) begin
        img_len = {img_len[LenW-ByteW-1:0], b};
      end else begin
        want_sum = {want_sum[SumW-ByteW-1:0], b};
      end
      hdr_taken = hdr_taken + 1'b1;
      if (hdr_taken == HdrBytes) begin
        pay_idx = '0;
        pay_sum = '0;
        // A zero-length image is judged as soon as its header is complete.
        if (img_len == '0) begin
          word.done_res    = 1'b1;
          word.checksum_ok = (pay_sum == want_sum);
          hdr_taken        = '0;
          awaited_words.push_back(word);
        end
      end
    end else begin
      word.write_valid = 1'b1;
      word.write_addr  = base_addr + pay_idx;
      word.write_data  = b;
      pay_sum          = pay_sum + b;
      pay_idx          = pay_idx + 1'b1;
      if (pay_idx >= img_len) begin
        word.done_res    = 1'b1;
        word.checksum_ok = (pay_sum == want_sum);
        hdr_taken        = '0;
        pay_idx          = '0;
        pay_sum          = '0;
      end
      awaited_words.push_back(word);
    end
  endtask

  // Offer one byte, with an optional gap first, and wait for its handshake.
  task automatic send_byte(input logic [ByteW-1:0] b);
    bit taken;
    if (src_gaps_on && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.rx_byte <= b;
    do begin
      @(negedge clk);
      taken = in_ch.ready;
      @(posedge clk);
    end while (!taken);
    track_loader_byte(b);
    bytes_sent++;
  endtask

  // Write the load base once nothing is in flight.
  task automatic write_load_base(input logic [AddrW-1:0] base);
    in_ch.valid <= 1'b0;
    while (awaited_words.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= base;
    @(posedge clk);
    cfg_we    <= 1'b0;
    base_addr = base;
  endtask

  // Payload bytes lean towards all-zero and all-one values.
  function automatic logic [ByteW-1:0] pick_payload_byte();
    int unsigned roll;
    roll = $urandom_range(0, 7);
    if (roll == 0) return 8'h00;
    if (roll == 1) return 8'hFF;
    return 8'($urandom_range(0, 255));
  endfunction

  // Mostly short images, with the odd long one.
  function automatic int unsigned pick_image_len();
    int unsigned roll;
    roll = $urandom_range(0, 9);
    if (roll < 7) return $urandom_range(1, 16);
    if (roll < 9) return $urandom_range(17, 64);
    return $urandom_range(65, 255);
  endfunction

  // Header: big-endian length, then big-endian expected sum.
  task automatic send_header(input logic [LenW-1:0] len, input logic [SumW-1:0] sum);
    for (int i = 3; i >= 0; i--) send_byte(len[8*i +: 8]);
    for (int i = 4; i >= 0; i--) send_byte(sum[8*i +: 8]);
  endtask

  // Send a header and the first cut bytes of a random payload of len bytes.
  task automatic send_image(input int unsigned len, input sum_kind_e kind,
                            input int unsigned cut);
    logic [ByteW-1:0] payload[$];
    logic [SumW-1:0]  total;
    total = '0;
    for (int unsigned i = 0; i < len; i++) begin
      payload.push_back(pick_payload_byte());
      total = total + payload[i];
    end
    case (kind)
      SumNear:   total = total + ($urandom_range(0, 1) ? 40'd1 : 40'hFF_FFFF_FFFF);
      SumRandom: total = {8'($urandom_range(0, 255)), $urandom()};
      default:   ;
    endcase
    send_header(len, total);
    for (int unsigned i = 0; i < cut && i < len; i++) send_byte(payload[i]);
  endtask

  // Finish whatever image the loader is in. The top three length bytes are
  // kept at zero so a completed header never asks for a huge payload.
  task automatic sync_to_header();
    while (hdr_taken != '0) begin
      send_byte(hdr_taken < LenBytes - 1 ? 8'h00 : pick_payload_byte());
    end
  endtask

  // Short burst of garbage from a header boundary, ending anywhere.
  task automatic send_garbage();
    int unsigned n;
    n = $urandom_range(1, 30);
    repeat (n) send_byte(hdr_taken < LenBytes - 1 ? 8'h00 : pick_payload_byte());
  endtask

  // Directed: a zero-length image with a failing all-ones sum, then a short
  // image of one all-ones and one all-zero byte whose sum matches.
  task automatic test_directed_images();
    src_gaps_on    = 1'b0;
    sink_stalls_on = 1'b0;
    send_header(32'd0, 40'hFF_FFFF_FFFF);
    send_header(32'd2, 40'h00_0000_00FF);
    send_byte(8'hFF);
    send_byte(8'h00);
  endtask

  // Random phases, each with its own load base and idling mix. Some phases
  // end part way through an image so the next base lands mid-image.
  task automatic test_random_images();
    logic [AddrW-1:0] base;
    int unsigned      roll;
    int unsigned      len;
    int               phase_start;
    for (int p = 0; p < NumPhases; p++) begin
      case (p)
        0:       base = 32'h0000_0000;
        1:       base = 32'hFFFF_FFFF;
        3:       base = 32'hFFFF_FFF0;
        4:       base = LoadBaseReset;
        6:       base = 32'h7FFF_FFFC;
        default: base = $urandom();
      endcase
      write_load_base(base);
      src_gaps_on    = (p % 3 != 2);
      sink_stalls_on = (p % 4 != 3);
      phase_start    = bytes_sent;
      while (bytes_sent - phase_start < PhaseBytes) begin
        sync_to_header();
        roll = $urandom_range(0, 99);
        if (roll < 55) begin
          len = pick_image_len();
          send_image(len, SumMatch, len);
        end else if (roll < 75) begin
          len = pick_image_len();
          send_image(len, roll < 65 ? SumNear : SumRandom, len);
        end else if (roll < 85) begin
          send_image(0, roll < 80 ? SumMatch : SumRandom, 0);
        end else begin
          send_garbage();
        end
      end
      if ($urandom_range(0, 1) == 1) begin
        sync_to_header();
        len = $urandom_range(8, 40);
        send_image(len, SumRandom, $urandom_range(1, len - 1));
      end
    end
  endtask

  // Backpressure: the receiver holds off while payload keeps coming, so the
  // result register fills and the input has to stall.
  task automatic test_result_backpressure();
    sync_to_header();
    src_gaps_on    = 1'b0;
    sink_stalls_on = 1'b0;
    in_ch.valid <= 1'b0;
    @(negedge clk);
    hold_len   = 80;
    hold_token = hold_token + 1;
    @(posedge clk);
    send_image(40, SumMatch, 40);
  endtask

  // Closing stretch without idling: a header with a large length and a
  // payload run whose addresses wrap past the top of memory.
  task automatic test_long_image();
    logic [LenW-1:0] len;
    src_gaps_on    = 1'b0;
    sink_stalls_on = 1'b0;
    sync_to_header();
    write_load_base(32'hFFFF_FF80);
    len = {8'($urandom_range(1, 255)), 24'($urandom())};
    send_header(len, {8'($urandom_range(0, 255)), $urandom()});
    repeat (160) send_byte(pick_payload_byte());
  endtask

  initial begin
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_wdata     = '0;
    in_ch.valid   = 1'b0;
    in_ch.rx_byte = '0;
    out_ch.ready  = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    base_addr = LoadBaseReset;
    hdr_taken = '0;
    img_len   = '0;
    want_sum  = '0;
    pay_idx   = '0;
    pay_sum   = '0;

    test_directed_images();
    test_random_images();
    test_result_backpressure();
    test_long_image();

    // Let the last words drain, then keep watching for strays.
    in_ch.valid <= 1'b0;
    while (awaited_words.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("serial_image_loader_unit_tb: clean");
    end else begin
      $display("serial_image_loader_unit_tb: errors");
    end
    $finish;
  end

endmodule
